// ----- rtl/mouse_event_accumulator_assert.svh -----
// assertion macros for the mouse event accumulator rtl
// depends on nothing; included by files that carry concurrent assertions
`ifndef MOUSE_EVENT_ACCUMULATOR_ASSERT_SVH
`define MOUSE_EVENT_ACCUMULATOR_ASSERT_SVH

// property that must hold at every sampled edge out of reset
`define MEA_ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mea: invariant violated");

// same-cycle implication
`define MEA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mea: same-cycle implication violated");

// next-cycle implication
`define MEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mea: next-cycle implication violated");

`endif

// ----- rtl/mea_pkg.sv -----
// shared types, constants and saturation helpers for the mouse event accumulator
// depends on nothing; used by mouse_event_accumulator and the testbench
package mea_pkg;

  localparam int DEFAULT_BUTTON_COUNT = 32;
  localparam int MAX_BUTTON_COUNT     = 64;
  localparam int STAMP_W              = 64;
  localparam int MOTION_W             = 16;
  localparam int WHEEL_W              = 32;
  localparam int BUTTON_NUM_W         = 16;
  localparam int MASK_W               = 32;

  localparam logic signed [MOTION_W:0] SAT_HI = 17'sd32767;
  localparam logic signed [MOTION_W:0] SAT_LO = -17'sd32767;
  localparam logic signed [WHEEL_W:0]  WHEEL_HI = 33'sd32767;
  localparam logic signed [WHEEL_W:0]  WHEEL_LO = -33'sd2147483648;

  typedef enum logic [2:0] {
    OP_MOVE        = 3'd0,
    OP_BUTTON_DOWN = 3'd1,
    OP_BUTTON_UP   = 3'd2,
    OP_WHEEL       = 3'd3,
    OP_READ_MOTION = 3'd4,
    OP_READ_WHEEL  = 3'd5,
    OP_CLEAR       = 3'd6,
    OP_READ_BUTTON = 3'd7
  } op_t;

  // accumulator plus delta, clamped to +/-32767
  function automatic logic signed [MOTION_W-1:0] sat_motion(
    input logic signed [MOTION_W-1:0] acc,
    input logic signed [MOTION_W-1:0] d
  );
    logic signed [MOTION_W:0] s;
    s = $signed({acc[MOTION_W-1], acc}) + $signed({d[MOTION_W-1], d});
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[MOTION_W-1:0];
  endfunction

  // wheel total plus step, clamped to 32767 above and the 32-bit minimum below
  function automatic logic signed [WHEEL_W-1:0] sat_wheel(
    input logic signed [WHEEL_W-1:0] acc,
    input logic signed [WHEEL_W-1:0] d
  );
    logic signed [WHEEL_W:0] s;
    s = $signed({acc[WHEEL_W-1], acc}) + $signed({d[WHEEL_W-1], d});
    if (s > WHEEL_HI) begin
      s = WHEEL_HI;
    end else if (s < WHEEL_LO) begin
      s = WHEEL_LO;
    end
    return s[WHEEL_W-1:0];
  endfunction

endpackage

// ----- rtl/mea_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on nothing; holds the per-button stamps of the accumulator
module mea_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mouse_event_accumulator.sv -----
// mouse event accumulator top level: input register, event logic, result register
// depends on mea_pkg, mea_ram and mouse_event_accumulator_assert.svh
//
// Takes one mouse event or host request per item on the ev channel and returns
// exactly one result item per input item on the res channel. Each item is
// captured in an input register (the per-button stamp ram is read on the
// same edge), all of its work is done by the logic between that register and
// the result register, and a new item is taken every cycle as long as the result
// register is free or being emptied, which is also when the input register
// hands its item on to the result register. Move events add into X and Y
// accumulators clamped to +/-32767, wheel events add into a wheel total clamped
// to 32767 above and the 32-bit minimum below, and button down/up events set or
// clear one bit of the pressed mask. An event whose stamp equals the last
// accepted stamp of its kind (per button for buttons) is dropped; stamps reset
// to zero. Events take effect only while the enabled register is set; requests
// always work. Read motion and read wheel return the accumulators and clear
// them, clear zeroes accumulators and mask but keeps stamps. The user must write
// the enabled register through cfg only while the block is idle; the block
// itself does not enforce this. There is no clearing pass: stamp ram entries
// carry a valid bit that reset clears.
module mouse_event_accumulator #(
  parameter int BUTTON_COUNT = mea_pkg::DEFAULT_BUTTON_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_enabled,
  // event / request items
  input  logic                                 ev_valid,
  output logic                                 ev_ready,
  input  logic [2:0]                           op,
  input  logic [mea_pkg::STAMP_W-1:0]          stamp,
  input  logic signed [mea_pkg::MOTION_W-1:0]  move_x,
  input  logic signed [mea_pkg::MOTION_W-1:0]  move_y,
  input  logic signed [mea_pkg::WHEEL_W-1:0]   wheel_step,
  input  logic [mea_pkg::BUTTON_NUM_W-1:0]     button_number,
  // result items
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic                                 handled,
  output logic signed [mea_pkg::MOTION_W-1:0]  motion_x,
  output logic signed [mea_pkg::MOTION_W-1:0]  motion_y,
  output logic signed [mea_pkg::WHEEL_W-1:0]   wheel_total,
  output logic [mea_pkg::MASK_W-1:0]           button_mask,
  output logic                                 button_pressed
);

  `include "mouse_event_accumulator_assert.svh"

  // button index width, at least one bit
  localparam int IW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam logic [mea_pkg::BUTTON_NUM_W-1:0] BTN_LIMIT =
    mea_pkg::BUTTON_NUM_W'(BUTTON_COUNT);

  // architectural state
  logic                                enabled;
  logic signed [mea_pkg::MOTION_W-1:0] acc_x;
  logic signed [mea_pkg::MOTION_W-1:0] acc_y;
  logic signed [mea_pkg::WHEEL_W-1:0]  acc_wheel;
  logic [BUTTON_COUNT-1:0]             pressed_bits;
  logic [BUTTON_COUNT-1:0]             stamp_valid;
  logic [mea_pkg::STAMP_W-1:0]         motion_stamp;
  logic [mea_pkg::STAMP_W-1:0]         wheel_stamp;

  // input register stage
  logic                                a_valid;
  mea_pkg::op_t                        a_op;
  logic [mea_pkg::STAMP_W-1:0]         a_stamp;
  logic signed [mea_pkg::MOTION_W-1:0] a_move_x;
  logic signed [mea_pkg::MOTION_W-1:0] a_move_y;
  logic signed [mea_pkg::WHEEL_W-1:0]  a_wheel_step;
  logic [mea_pkg::BUTTON_NUM_W-1:0]    a_button_number;
  // forward of a stamp written on the same edge the ram was read
  logic                                byp;
  logic [mea_pkg::STAMP_W-1:0]         byp_stamp;

  logic                                ev_accept;
  logic                                a_adv;
  logic                                commit;

  // incoming button index for the stamp ram read
  logic [mea_pkg::BUTTON_NUM_W-1:0]    ev_idx16;

  // stage logic
  logic [mea_pkg::BUTTON_NUM_W-1:0]    idx16;
  logic                                btn_ok;
  logic [IW-1:0]                       bidx;
  logic                                q_ok;
  logic [IW-1:0]                       qidx;
  logic [mea_pkg::STAMP_W-1:0]         ram_q;
  logic [mea_pkg::STAMP_W-1:0]         kept_stamp;
  logic                                btn_we;

  logic signed [mea_pkg::MOTION_W-1:0] acc_x_next;
  logic signed [mea_pkg::MOTION_W-1:0] acc_y_next;
  logic signed [mea_pkg::WHEEL_W-1:0]  acc_wheel_next;
  logic [BUTTON_COUNT-1:0]             pressed_bits_next;
  logic [mea_pkg::STAMP_W-1:0]         motion_stamp_next;
  logic [mea_pkg::STAMP_W-1:0]         wheel_stamp_next;
  logic                                handled_next;
  logic signed [mea_pkg::MOTION_W-1:0] motion_x_next;
  logic signed [mea_pkg::MOTION_W-1:0] motion_y_next;
  logic signed [mea_pkg::WHEEL_W-1:0]  wheel_total_next;
  logic                                button_pressed_next;
  logic [mea_pkg::MAX_BUTTON_COUNT-1:0] mask_wide;

  // handshakes: the input register moves on whenever the result register is free
  // or being emptied, so one item enters per cycle
  assign cfg_ready = 1'b1;
  assign a_adv     = !res_valid || res_ready;
  assign ev_ready  = !a_valid || a_adv;
  assign ev_accept = ev_valid && ev_ready;
  assign commit    = a_valid && a_adv;

  assign ev_idx16 = button_number - mea_pkg::BUTTON_NUM_W'(1);

  // per-button stamps live in a ram read on the accept edge
  mea_ram #(
    .WIDTH(mea_pkg::STAMP_W),
    .DEPTH(BUTTON_COUNT),
    .AW   (IW)
  ) u_stamp_ram (
    .clk  (clk),
    .we   (btn_we),
    .waddr(bidx),
    .wdata(a_stamp),
    .re   (ev_accept),
    .raddr(ev_idx16[IW-1:0]),
    .rdata(ram_q)
  );

  // button decode for the item in the input register
  assign idx16  = a_button_number - mea_pkg::BUTTON_NUM_W'(1);
  assign btn_ok = idx16 < BTN_LIMIT;
  assign bidx   = idx16[IW-1:0];
  assign q_ok   = a_button_number < BTN_LIMIT;
  assign qidx   = a_button_number[IW-1:0];

  // never-written entries read as stamp zero
  always_comb begin
    if (byp) begin
      kept_stamp = byp_stamp;
    end else if (btn_ok && stamp_valid[bidx]) begin
      kept_stamp = ram_q;
    end else begin
      kept_stamp = '0;
    end
  end

  // all the work of one item
  always_comb begin
    acc_x_next          = acc_x;
    acc_y_next          = acc_y;
    acc_wheel_next      = acc_wheel;
    pressed_bits_next   = pressed_bits;
    motion_stamp_next   = motion_stamp;
    wheel_stamp_next    = wheel_stamp;
    handled_next        = 1'b0;
    motion_x_next       = '0;
    motion_y_next       = '0;
    wheel_total_next    = '0;
    button_pressed_next = 1'b0;
    btn_we              = 1'b0;

    unique case (a_op)
      mea_pkg::OP_MOVE: begin
        if (enabled && a_stamp != motion_stamp) begin
          acc_x_next        = mea_pkg::sat_motion(acc_x, a_move_x);
          acc_y_next        = mea_pkg::sat_motion(acc_y, a_move_y);
          motion_stamp_next = a_stamp;
          handled_next      = 1'b1;
        end
      end
      mea_pkg::OP_BUTTON_DOWN, mea_pkg::OP_BUTTON_UP: begin
        if (enabled && btn_ok && a_stamp != kept_stamp) begin
          pressed_bits_next[bidx] = (a_op == mea_pkg::OP_BUTTON_DOWN);
          handled_next            = 1'b1;
          btn_we                  = commit;
        end
      end
      mea_pkg::OP_WHEEL: begin
        if (enabled && a_stamp != wheel_stamp) begin
          acc_wheel_next   = mea_pkg::sat_wheel(acc_wheel, a_wheel_step);
          wheel_stamp_next = a_stamp;
          handled_next     = 1'b1;
        end
      end
      mea_pkg::OP_READ_MOTION: begin
        motion_x_next = acc_x;
        motion_y_next = acc_y;
        acc_x_next    = '0;
        acc_y_next    = '0;
      end
      mea_pkg::OP_READ_WHEEL: begin
        wheel_total_next = acc_wheel;
        acc_wheel_next   = '0;
      end
      mea_pkg::OP_CLEAR: begin
        acc_x_next        = '0;
        acc_y_next        = '0;
        acc_wheel_next    = '0;
        pressed_bits_next = '0;
      end
      mea_pkg::OP_READ_BUTTON: begin
        button_pressed_next = q_ok && pressed_bits[qidx];
      end
    endcase
  end

  // mask output is the low bits of the pressed state after the item
  assign mask_wide = mea_pkg::MAX_BUTTON_COUNT'(pressed_bits_next);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enabled <= cfg_enabled;
    end
  end

  // input register; the bypass catches a stamp written on the edge the ram is read
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      byp     <= 1'b0;
    end else begin
      if (ev_accept) begin
        a_valid <= 1'b1;
        byp     <= btn_we && (bidx == ev_idx16[IW-1:0]);
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_accept) begin
      a_op            <= mea_pkg::op_t'(op);
      a_stamp         <= stamp;
      a_move_x        <= move_x;
      a_move_y        <= move_y;
      a_wheel_step    <= wheel_step;
      a_button_number <= button_number;
      byp_stamp       <= a_stamp;
    end
  end

  // state update when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x        <= '0;
      acc_y        <= '0;
      acc_wheel    <= '0;
      pressed_bits <= '0;
      stamp_valid  <= '0;
      motion_stamp <= '0;
      wheel_stamp  <= '0;
    end else if (commit) begin
      acc_x        <= acc_x_next;
      acc_y        <= acc_y_next;
      acc_wheel    <= acc_wheel_next;
      pressed_bits <= pressed_bits_next;
      motion_stamp <= motion_stamp_next;
      wheel_stamp  <= wheel_stamp_next;
      if (btn_we) begin
        stamp_valid[bidx] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      handled        <= handled_next;
      motion_x       <= motion_x_next;
      motion_y       <= motion_y_next;
      wheel_total    <= wheel_total_next;
      button_mask    <= mask_wide[mea_pkg::MASK_W-1:0];
      button_pressed <= button_pressed_next;
    end
  end

  // motion accumulators never reach the negative extreme
  `MEA_ASSERT_HOLDS(a_motion_range, clk, rst, acc_x != 16'sh8000 && acc_y != 16'sh8000)
  // wheel total never exceeds its upper clamp
  `MEA_ASSERT_HOLDS(a_wheel_range, clk, rst, !(acc_wheel > 32'sd32767))
  // stamp ram is written only by an item leaving the input register
  `MEA_ASSERT_IMP(a_ram_write, clk, rst, btn_we, a_valid && a_adv && btn_ok)
  // input stalls only when both stages are full and the result is held
  `MEA_ASSERT_IMP(a_stall_cause, clk, rst, !ev_ready, a_valid && res_valid && !res_ready)
  // read motion leaves the accumulators cleared
  `MEA_ASSERT_NEXT(a_read_clears, clk, rst, commit && a_op == mea_pkg::OP_READ_MOTION, acc_x == 16'sd0 && acc_y == 16'sd0)

endmodule

// ----- verif/tb.sv -----
// testbench for mouse_event_accumulator: directed table, then random phases
// depends on mea_pkg and the rtl top; results are checked against the directed table or an in-bench predictor
module tb;
  import mea_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 11;
  localparam int TIMEOUT_CYCLES  = 400000;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int BUTTONS         = 32;
  localparam int MOTION_LIMIT    = 32767;
  localparam longint WHEEL_CEIL  = 64'sd32767;
  localparam longint WHEEL_FLOOR = -64'sd2147483648;
  localparam int DISABLED_ROWS   = 3;
  localparam int PHASES          = 6;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    op_t                        op;
    logic [STAMP_W-1:0]         stamp;
    logic signed [MOTION_W-1:0] dx;
    logic signed [MOTION_W-1:0] dy;
    logic signed [WHEEL_W-1:0]  wstep;
    logic [BUTTON_NUM_W-1:0]    btn;
  } mouse_ev_t;

  typedef struct {
    logic                       handled;
    logic signed [MOTION_W-1:0] mx;
    logic signed [MOTION_W-1:0] my;
    logic signed [WHEEL_W-1:0]  wt;
    logic [MASK_W-1:0]          mask;
    logic                       pressed;
  } mouse_report_t;

  typedef struct {
    mouse_ev_t     ev;
    bit            typed;
    mouse_report_t want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_enabled = 1'b0;
  logic ev_valid = 1'b0;
  logic ev_ready;
  logic [2:0] op = '0;
  logic [STAMP_W-1:0] stamp = '0;
  logic signed [MOTION_W-1:0] move_x = '0;
  logic signed [MOTION_W-1:0] move_y = '0;
  logic signed [WHEEL_W-1:0] wheel_step = '0;
  logic [BUTTON_NUM_W-1:0] button_number = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic handled;
  logic signed [MOTION_W-1:0] motion_x;
  logic signed [MOTION_W-1:0] motion_y;
  logic signed [WHEEL_W-1:0] wheel_total;
  logic [MASK_W-1:0] button_mask;
  logic button_pressed;

  // predictor state
  logic                       events_on;
  logic signed [MOTION_W-1:0] acc_x;
  logic signed [MOTION_W-1:0] acc_y;
  logic signed [WHEEL_W-1:0]  acc_w;
  logic [MASK_W-1:0]          held;
  logic [STAMP_W-1:0]         press_seen [BUTTONS];
  logic [STAMP_W-1:0]         move_seen;
  logic [STAMP_W-1:0]         wheel_seen;

  mouse_report_t expected_reports[$];
  step_row_t     dir_rows[$];
  mouse_report_t no_report;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // random phases: idling, enable setting, counted items, long receiver hold
  idle_mode_t plan_mode  [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                      IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
  bit         plan_on    [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  int         plan_items [PHASES] = '{420, 250, 100, 250, 250, 250};
  bit         plan_hold  [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  mouse_event_accumulator u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_enabled   (cfg_enabled),
    .ev_valid      (ev_valid),
    .ev_ready      (ev_ready),
    .op            (op),
    .stamp         (stamp),
    .move_x        (move_x),
    .move_y        (move_y),
    .wheel_step    (wheel_step),
    .button_number (button_number),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .handled       (handled),
    .motion_x      (motion_x),
    .motion_y      (motion_y),
    .wheel_total   (wheel_total),
    .button_mask   (button_mask),
    .button_pressed(button_pressed)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [MOTION_W-1:0] clamp_motion(int s);
    if (s > MOTION_LIMIT) s = MOTION_LIMIT;
    else if (s < -MOTION_LIMIT) s = -MOTION_LIMIT;
    return s[MOTION_W-1:0];
  endfunction

  // applies one item to the predictor state and returns the result it should give
  function automatic mouse_report_t accumulate_event(mouse_ev_t e);
    mouse_report_t r;
    longint sum_w;
    logic [BUTTON_NUM_W-1:0] slot;
    r.handled = 1'b0;
    r.mx = '0;
    r.my = '0;
    r.wt = '0;
    r.pressed = 1'b0;
    slot = e.btn - 16'd1;
    case (e.op)
      OP_MOVE: begin
        if (events_on && e.stamp != move_seen) begin
          acc_x = clamp_motion(acc_x + e.dx);
          acc_y = clamp_motion(acc_y + e.dy);
          move_seen = e.stamp;
          r.handled = 1'b1;
        end
      end
      OP_BUTTON_DOWN, OP_BUTTON_UP: begin
        // button numbers count from one; zero wraps out of range
        if (events_on && slot < BUTTONS && press_seen[slot[4:0]] != e.stamp) begin
          held[slot[4:0]] = (e.op == OP_BUTTON_DOWN);
          press_seen[slot[4:0]] = e.stamp;
          r.handled = 1'b1;
        end
      end
      OP_WHEEL: begin
        if (events_on && e.stamp != wheel_seen) begin
          sum_w = longint'(acc_w) + longint'(e.wstep);
          if (sum_w > WHEEL_CEIL) sum_w = WHEEL_CEIL;
          else if (sum_w < WHEEL_FLOOR) sum_w = WHEEL_FLOOR;
          acc_w = sum_w[WHEEL_W-1:0];
          wheel_seen = e.stamp;
          r.handled = 1'b1;
        end
      end
      OP_READ_MOTION: begin
        r.mx = acc_x;
        r.my = acc_y;
        acc_x = '0;
        acc_y = '0;
      end
      OP_READ_WHEEL: begin
        r.wt = acc_w;
        acc_w = '0;
      end
      OP_CLEAR: begin
        // stamps survive a clear
        acc_x = '0;
        acc_y = '0;
        acc_w = '0;
        held = '0;
      end
      default: begin
        if (e.btn < BUTTONS) r.pressed = held[e.btn[4:0]];
      end
    endcase
    r.mask = held;
    return r;
  endfunction

  function automatic mouse_ev_t mk_ev(op_t o, logic [STAMP_W-1:0] st,
                                      logic signed [MOTION_W-1:0] dx,
                                      logic signed [MOTION_W-1:0] dy,
                                      logic signed [WHEEL_W-1:0] w,
                                      logic [BUTTON_NUM_W-1:0] b);
    mouse_ev_t e;
    e.op = o;
    e.stamp = st;
    e.dx = dx;
    e.dy = dy;
    e.wstep = w;
    e.btn = b;
    return e;
  endfunction

  function automatic mouse_report_t mk_report(logic h, logic signed [MOTION_W-1:0] mx,
                                              logic signed [MOTION_W-1:0] my,
                                              logic signed [WHEEL_W-1:0] wt,
                                              logic [MASK_W-1:0] mask, logic pr);
    mouse_report_t r;
    r.handled = h;
    r.mx = mx;
    r.my = my;
    r.wt = wt;
    r.mask = mask;
    r.pressed = pr;
    return r;
  endfunction

  function automatic void add_row(mouse_ev_t e, bit typed, mouse_report_t want);
    step_row_t row;
    row.ev = e;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  // directed stimulus; the first rows run while events are still disabled
  function automatic void load_rows();
    mouse_report_t quiet;
    quiet = mk_report(1'b0, '0, '0, '0, '0, 1'b0);
    // disabled: events do nothing, requests still answer
    add_row(mk_ev(OP_MOVE, 64'd5, 16'sd100, -16'sd100, '0, 16'd0), 1'b1, quiet);
    add_row(mk_ev(OP_BUTTON_DOWN, 64'd9, '0, '0, '0, 16'd1), 1'b1, quiet);
    add_row(mk_ev(OP_READ_BUTTON, 64'd0, '0, '0, '0, 16'd0), 1'b1, quiet);
    // motion extremes and saturation
    add_row(mk_ev(OP_MOVE, 64'd1, 16'sd32767, 16'sh8000, '0, 16'd0), 1'b1,
            mk_report(1'b1, '0, '0, '0, '0, 1'b0));
    add_row(mk_ev(OP_MOVE, 64'd2, 16'sd32767, 16'sh8000, '0, 16'd0), 1'b1,
            mk_report(1'b1, '0, '0, '0, '0, 1'b0));
    add_row(mk_ev(OP_READ_MOTION, 64'd0, '0, '0, '0, 16'd0), 1'b1,
            mk_report(1'b0, 16'sd32767, -16'sd32767, '0, '0, 1'b0));
    // repeated stamp on a move
    add_row(mk_ev(OP_MOVE, 64'd2, 16'sd5, 16'sd5, '0, 16'd0), 1'b1, quiet);
    add_row(mk_ev(OP_READ_MOTION, 64'd0, '0, '0, '0, 16'd0), 1'b1, quiet);
    // wheel: first stamp zero dropped, then both clamps
    add_row(mk_ev(OP_WHEEL, 64'd0, '0, '0, 32'sd5, 16'd0), 1'b1, quiet);
    add_row(mk_ev(OP_WHEEL, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 32'sd2147483647, 16'd0),
            1'b1, mk_report(1'b1, '0, '0, '0, '0, 1'b0));
    add_row(mk_ev(OP_WHEEL, 64'd1, '0, '0, 32'sh8000_0000, 16'd0), 1'b1,
            mk_report(1'b1, '0, '0, '0, '0, 1'b0));
    add_row(mk_ev(OP_WHEEL, 64'd2, '0, '0, 32'sh8000_0000, 16'd0), 1'b1,
            mk_report(1'b1, '0, '0, '0, '0, 1'b0));
    add_row(mk_ev(OP_READ_WHEEL, 64'd0, '0, '0, '0, 16'd0), 1'b1,
            mk_report(1'b0, '0, '0, 32'sh8000_0000, '0, 1'b0));
    // buttons out of range, stamp zero, both ends of the mask
    add_row(mk_ev(OP_BUTTON_DOWN, 64'd3, '0, '0, '0, 16'd0), 1'b1, quiet);
    add_row(mk_ev(OP_BUTTON_DOWN, 64'd3, '0, '0, '0, 16'd33), 1'b1, quiet);
    add_row(mk_ev(OP_BUTTON_DOWN, 64'd3, '0, '0, '0, 16'hFFFF), 1'b1, quiet);
    add_row(mk_ev(OP_BUTTON_DOWN, 64'd0, '0, '0, '0, 16'd1), 1'b1, quiet);
    add_row(mk_ev(OP_BUTTON_DOWN, 64'd3, '0, '0, '0, 16'd1), 1'b1,
            mk_report(1'b1, '0, '0, '0, 32'h0000_0001, 1'b0));
    add_row(mk_ev(OP_BUTTON_DOWN, 64'd3, '0, '0, '0, 16'd32), 1'b1,
            mk_report(1'b1, '0, '0, '0, 32'h8000_0001, 1'b0));
    add_row(mk_ev(OP_BUTTON_DOWN, 64'd3, '0, '0, '0, 16'd32), 1'b1,
            mk_report(1'b0, '0, '0, '0, 32'h8000_0001, 1'b0));
    add_row(mk_ev(OP_READ_BUTTON, 64'd0, '0, '0, '0, 16'd31), 1'b1,
            mk_report(1'b0, '0, '0, '0, 32'h8000_0001, 1'b1));
    add_row(mk_ev(OP_READ_BUTTON, 64'd0, '0, '0, '0, 16'd32), 1'b1,
            mk_report(1'b0, '0, '0, '0, 32'h8000_0001, 1'b0));
    add_row(mk_ev(OP_BUTTON_UP, 64'd4, '0, '0, '0, 16'd1), 1'b1,
            mk_report(1'b1, '0, '0, '0, 32'h8000_0000, 1'b0));
    add_row(mk_ev(OP_MOVE, 64'd3, -16'sd7, 16'sd9, '0, 16'd0), 1'b0, quiet);
    // clear keeps stamps, drops everything else
    add_row(mk_ev(OP_CLEAR, 64'd0, '0, '0, '0, 16'd0), 1'b1, quiet);
    add_row(mk_ev(OP_READ_MOTION, 64'd0, '0, '0, '0, 16'd0), 1'b1, quiet);
  endfunction

  // random item: mostly fresh stamps and in-range buttons, some repeats and junk
  function automatic mouse_ev_t pick_event();
    mouse_ev_t e;
    int pick;
    logic [31:0] rnd;
    logic [BUTTON_NUM_W-1:0] slot;
    pick = $urandom_range(99);
    if (pick < 26) e.op = OP_MOVE;
    else if (pick < 40) e.op = OP_BUTTON_DOWN;
    else if (pick < 54) e.op = OP_BUTTON_UP;
    else if (pick < 70) e.op = OP_WHEEL;
    else if (pick < 78) e.op = OP_READ_MOTION;
    else if (pick < 85) e.op = OP_READ_WHEEL;
    else if (pick < 88) e.op = OP_CLEAR;
    else e.op = OP_READ_BUTTON;
    e.stamp = {$urandom, $urandom};
    rnd = $urandom;
    if ($urandom_range(99) < 20) begin
      e.dx = rnd[15:0];
      e.dy = rnd[31:16];
    end else begin
      e.dx = 16'(int'($urandom_range(600)) - 300);
      e.dy = 16'(int'($urandom_range(600)) - 300);
    end
    if ($urandom_range(99) < 15) e.wstep = $urandom;
    else e.wstep = 32'(int'($urandom_range(3000)) - 1500);
    pick = $urandom_range(99);
    rnd = $urandom;
    if (e.op == OP_READ_BUTTON) begin
      if (pick < 85) e.btn = 16'($urandom_range(BUTTONS - 1));
      else e.btn = rnd[15:0];
    end else if (pick < 80) begin
      e.btn = 16'($urandom_range(BUTTONS, 1));
    end else if (pick < 88) begin
      e.btn = '0;
    end else begin
      e.btn = rnd[15:0];
    end
    // now and then reuse the kept stamp so the event gets dropped
    pick = $urandom_range(99);
    slot = e.btn - 16'd1;
    if (pick < 3) begin
      e.stamp = '0;
    end else if (pick < 12) begin
      case (e.op)
        OP_MOVE: e.stamp = move_seen;
        OP_WHEEL: e.stamp = wheel_seen;
        OP_BUTTON_DOWN, OP_BUTTON_UP: begin
          if (slot < BUTTONS) e.stamp = press_seen[slot[4:0]];
        end
        default: ;
      endcase
    end
    return e;
  endfunction

  function automatic void set_idle(idle_mode_t m);
    send_idle_pct  = (m == IDLE_SENDER) ? 84 : (m == IDLE_BOTH) ? 20 : 0;
    recv_stall_pct = (m == IDLE_RECEIVER) ? 84 : (m == IDLE_BOTH) ? 20 : 0;
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic offer(input mouse_ev_t e, input bit typed, input mouse_report_t want,
                       output mouse_report_t got);
    while ($urandom_range(99) < send_idle_pct) begin
      ev_valid <= 1'b0;
      @(negedge clk);
    end
    ev_valid      <= 1'b1;
    op            <= e.op;
    stamp         <= e.stamp;
    move_x        <= e.dx;
    move_y        <= e.dy;
    wheel_step    <= e.wstep;
    button_number <= e.btn;
    @(posedge clk);
    while (!ev_ready) @(posedge clk);
    got = accumulate_event(e);
    if (typed) expected_reports.push_back(want);
    else expected_reports.push_back(got);
    @(negedge clk);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // only while idle
  task automatic write_enable(input logic v);
    cfg_valid   <= 1'b1;
    cfg_enabled <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    events_on = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(string name, longint want, longint seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      errors++;
    end
  endfunction

  // receiver: random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left--;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : collect
    mouse_report_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_reports.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("handled", want.handled, handled);
        check_field("motion_x", want.mx, motion_x);
        check_field("motion_y", want.my, motion_y);
        check_field("wheel_total", want.wt, wheel_total);
        check_field("button_mask", want.mask, button_mask);
        check_field("button_pressed", want.pressed, button_pressed);
      end
    end
  end

  initial begin
    mouse_ev_t e;
    mouse_report_t got;
    int taken;
    events_on = 1'b0;
    acc_x = '0;
    acc_y = '0;
    acc_w = '0;
    held = '0;
    move_seen = '0;
    wheel_seen = '0;
    for (int i = 0; i < BUTTONS; i++) press_seen[i] = '0;
    no_report = mk_report(1'b0, '0, '0, '0, '0, 1'b0);
    load_rows();
    set_idle(IDLE_NONE);
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == DISABLED_ROWS) begin
        ev_valid <= 1'b0;
        drain();
        write_enable(1'b1);
      end
      offer(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want, got);
    end
    ev_valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_enable(plan_on[p]);
      set_idle(plan_mode[p]);
      if (plan_hold[p]) hold_req = 1'b1;
      taken = 0;
      while (taken < plan_items[p]) begin
        e = pick_event();
        offer(e, 1'b0, no_report, got);
        taken++;
      end
      ev_valid <= 1'b0;
      drain();
    end

    if (expected_reports.size() != 0) begin
      $error("%0d expected results never arrived", expected_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("tb: errors");
    $finish;
  end

endmodule
